[rtl/core/i2cm_pkg.sv]
`default_nettype none
package i2cm_pkg;

	localparam int MAX_BYTES_DEF = 16;
	localparam logic [7:0] QD_RESET = 8'd5;
	localparam logic [7:0] ADDR_MASK = 8'hFE;
	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam logic RW_BIT_READ = 1'b1;
	localparam logic RW_BIT_WRITE = 1'b0;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_WR_ADDR_NACK = 3'd1;
	localparam logic [2:0] ST_WR_REG_NACK = 3'd2;
	localparam logic [2:0] ST_RD_ADDR_NACK = 3'd3;
	localparam logic [2:0] ST_RD_REG_NACK = 3'd4;
	localparam logic [2:0] ST_RD_ADDRR_NACK = 3'd5;

	typedef enum logic [1:0] {
		FN_PUSH = 2'd0,
		FN_START_WR = 2'd1,
		FN_START_RD = 2'd2,
		FN_TICK = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_START = 5'd1,
		PH_AW_TX = 5'd2,
		PH_AW_ACK = 5'd3,
		PH_REG_TX = 5'd4,
		PH_REG_ACK = 5'd5,
		PH_DAT_TX = 5'd6,
		PH_DAT_ACK = 5'd7,
		PH_RSTART = 5'd8,
		PH_AR_TX = 5'd9,
		PH_AR_ACK = 5'd10,
		PH_RX_PRE = 5'd11,
		PH_RX_BIT = 5'd12,
		PH_RX_ANS = 5'd13,
		PH_STOP = 5'd14
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] data_byte;
		logic [4:0] count;
		logic sda;
	} item_t;

	typedef struct packed {
		logic scl;
		logic scl_oe;
		logic sda;
		logic sda_oe;
	} pins_t;

	localparam pins_t PINS_IDLE = '{scl: 1'b1, scl_oe: 1'b0, sda: 1'b1, sda_oe: 1'b0};

endpackage
`default_nettype wire

[rtl/core/i2cm_ram.sv]
`default_nettype none
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/i2cm_front.sv]
`default_nettype none
module i2cm_front import i2cm_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] func,
	input wire logic [6:0] dev_addr,
	input wire logic [7:0] reg_addr,
	input wire logic [7:0] data_byte,
	input wire logic [4:0] byte_count,
	input wire logic sda_in,
	input wire logic q_pop,
	output logic q_valid,
	output item_t q_item
);
	item_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	item_t cls;
	logic push;
	logic [4:0] cnt_clamp;

	always_comb begin
		cls.kind = kind_t'(func);
		cls.dev_addr = dev_addr;
		cls.reg_addr = reg_addr;
		cls.data_byte = data_byte;
		cls.sda = sda_in;
		cnt_clamp = (32'(byte_count) > MAX_BYTES) ? 5'(MAX_BYTES) : byte_count;
		if (kind_t'(func) == FN_START_RD && cnt_clamp == 5'd0) begin
			cnt_clamp = 5'd1;
		end
		cls.count = cnt_clamp;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

[rtl/core/i2cm_back.sv]
`default_nettype none
module i2cm_back import i2cm_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic q_valid,
	input wire item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic scl_out,
	output logic scl_oe,
	output logic sda_out,
	output logic sda_oe,
	output logic [7:0] rd_data,
	output logic rd_valid,
	output logic done_res,
	output logic [2:0] status,
	output logic [4:0] bytes_done
);
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CW = $clog2(MAX_BYTES + 1);

	logic [7:0] qd_q;
	phase_t phase_q, n_phase;
	logic [1:0] slot_q, n_slot;
	logic [7:0] delay_q, n_delay;
	logic [2:0] bit_q, n_bit;
	logic [7:0] shift_q, n_shift;
	logic [CW-1:0] byte_q, n_byte;
	logic [CW-1:0] fill_q, n_fill;
	logic [6:0] taddr_q, n_taddr;
	logic [7:0] treg_q, n_treg;
	logic [CW-1:0] goal_q, n_goal;
	logic rd_q, n_rd;
	logic [2:0] stat_q, n_stat;
	logic nack_q, n_nack;
	pins_t pins_q, n_pins;
	logic out_valid_q;
	logic enter;
	logic o_rvalid;
	logic [7:0] o_rdata;
	logic o_done;
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic [CW-1:0] byte_inc;
	logic [1:0] last_slot;

	function automatic pins_t pins_for(phase_t ph, logic [1:0] sl, logic [7:0] sh,
	                                   logic ans_nack);
		pins_t p;
		p = PINS_IDLE;
		case (ph)
			PH_START, PH_RSTART: begin
				p = '{scl: (sl < 2'd2), scl_oe: 1'b1, sda: (sl == 2'd0), sda_oe: 1'b1};
			end
			PH_AW_TX, PH_REG_TX, PH_DAT_TX, PH_AR_TX: begin
				p = '{scl: (sl == 2'd1), scl_oe: 1'b1, sda: |(sh & MSB_MASK), sda_oe: 1'b1};
			end
			PH_AW_ACK, PH_REG_ACK, PH_DAT_ACK, PH_AR_ACK, PH_RX_BIT: begin
				p = '{scl: (sl < 2'd2), scl_oe: 1'b1, sda: 1'b1, sda_oe: 1'b0};
			end
			PH_RX_PRE: begin
				p = '{scl: 1'b0, scl_oe: 1'b1, sda: 1'b1, sda_oe: 1'b0};
			end
			PH_RX_ANS: begin
				p = '{scl: (sl == 2'd1), scl_oe: 1'b1, sda: ans_nack, sda_oe: 1'b1};
			end
			PH_STOP: begin
				p = '{scl: 1'b1, scl_oe: 1'b1, sda: sl[0], sda_oe: 1'b1};
			end
			default: begin
				p = PINS_IDLE;
			end
		endcase
		return p;
	endfunction

	assign q_pop = q_valid && (!out_valid_q || out_ready);
	assign byte_inc = byte_q + CW'(1);
	assign ram_raddr = (phase_q == PH_DAT_ACK) ? byte_inc[AW-1:0] : AW'(0);
	assign ram_we = q_pop && q_item.kind == FN_PUSH && phase_q == PH_IDLE
		&& 32'(fill_q) < MAX_BYTES;

	i2cm_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_wbuf (
		.clk(clk),
		.we(ram_we),
		.waddr(fill_q[AW-1:0]),
		.wdata(q_item.data_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		case (phase_q)
			PH_RX_PRE: last_slot = 2'd0;
			PH_STOP: last_slot = 2'd1;
			default: last_slot = 2'd2;
		endcase
	end

	always_comb begin
		n_phase = phase_q;
		n_slot = slot_q;
		n_delay = delay_q;
		n_bit = bit_q;
		n_shift = shift_q;
		n_byte = byte_q;
		n_fill = fill_q;
		n_taddr = taddr_q;
		n_treg = treg_q;
		n_goal = goal_q;
		n_rd = rd_q;
		n_stat = stat_q;
		n_nack = nack_q;
		n_pins = pins_q;
		enter = 1'b0;
		o_rvalid = 1'b0;
		o_rdata = 8'd0;
		o_done = 1'b0;
		if (q_pop) begin
			if (q_item.kind == FN_TICK) begin
				if (phase_q != PH_IDLE) begin
					if (delay_q > 8'd1) begin
						n_delay = delay_q - 8'd1;
					end else begin
						n_delay = 8'd0;
						if (slot_q == 2'd0) begin
							if (phase_q == PH_AW_ACK || phase_q == PH_REG_ACK
								|| phase_q == PH_DAT_ACK || phase_q == PH_AR_ACK) begin
								n_nack = q_item.sda;
							end
							if (phase_q == PH_RX_BIT) begin
								n_shift = {shift_q[6:0], q_item.sda};
								if (bit_q == 3'd7) begin
									o_rvalid = 1'b1;
									o_rdata = n_shift;
								end
							end
						end
						if (phase_q == PH_STOP && slot_q >= 2'd1) begin
							n_pins = PINS_IDLE;
							o_done = 1'b1;
							n_phase = PH_IDLE;
							n_slot = 2'd0;
						end else if (slot_q < last_slot) begin
							n_slot = slot_q + 2'd1;
							enter = 1'b1;
						end else begin
							enter = 1'b1;
							n_slot = 2'd0;
							case (phase_q)
								PH_START: begin
									n_shift = {n_taddr, RW_BIT_WRITE} & ADDR_MASK;
									n_bit = 3'd0;
									n_phase = PH_AW_TX;
								end
								PH_AW_TX, PH_REG_TX, PH_DAT_TX, PH_AR_TX: begin
									if (bit_q < 3'd7) begin
										n_bit = bit_q + 3'd1;
										n_shift = {shift_q[6:0], 1'b0};
									end else begin
										n_phase = phase_t'(phase_q + 5'd1);
									end
								end
								PH_AW_ACK: begin
									if (n_nack) begin
										n_stat = rd_q ? ST_RD_ADDR_NACK : ST_WR_ADDR_NACK;
										n_phase = PH_STOP;
									end else begin
										n_shift = treg_q;
										n_bit = 3'd0;
										n_phase = PH_REG_TX;
									end
								end
								PH_REG_ACK: begin
									if (n_nack) begin
										n_stat = rd_q ? ST_RD_REG_NACK : ST_WR_REG_NACK;
										n_phase = PH_STOP;
									end else if (rd_q) begin
										n_phase = PH_RSTART;
									end else if (goal_q == '0) begin
										n_stat = ST_OK;
										n_phase = PH_STOP;
									end else begin
										n_shift = ram_rdata;
										n_bit = 3'd0;
										n_phase = PH_DAT_TX;
									end
								end
								PH_DAT_ACK: begin
									if (n_nack) begin
										n_stat = (byte_inc == goal_q) ? ST_OK : ST_WR_REG_NACK;
										n_phase = PH_STOP;
									end else begin
										n_byte = byte_inc;
										if (byte_inc >= goal_q) begin
											n_stat = ST_OK;
											n_phase = PH_STOP;
										end else begin
											n_shift = ram_rdata;
											n_bit = 3'd0;
											n_phase = PH_DAT_TX;
										end
									end
								end
								PH_RSTART: begin
									n_shift = ({taddr_q, RW_BIT_WRITE} & ADDR_MASK)
										| {7'd0, RW_BIT_READ};
									n_bit = 3'd0;
									n_phase = PH_AR_TX;
								end
								PH_AR_ACK: begin
									if (n_nack) begin
										n_stat = ST_RD_ADDRR_NACK;
										n_phase = PH_STOP;
									end else begin
										n_phase = PH_RX_PRE;
									end
								end
								PH_RX_PRE: begin
									n_bit = 3'd0;
									n_shift = 8'd0;
									n_phase = PH_RX_BIT;
								end
								PH_RX_BIT: begin
									if (bit_q < 3'd7) begin
										n_bit = bit_q + 3'd1;
									end else begin
										n_byte = byte_inc;
										n_phase = PH_RX_ANS;
									end
								end
								PH_RX_ANS: begin
									if (byte_q >= goal_q) begin
										n_stat = ST_OK;
										n_phase = PH_STOP;
									end else begin
										n_phase = PH_RX_PRE;
									end
								end
								default: begin
									n_phase = PH_IDLE;
								end
							endcase
						end
					end
				end
			end else if (phase_q == PH_IDLE) begin
				if (q_item.kind == FN_PUSH) begin
					if (ram_we) begin
						n_fill = fill_q + CW'(1);
					end
				end else begin
					n_rd = (q_item.kind == FN_START_RD);
					if (q_item.kind == FN_START_WR) begin
						n_fill = '0;
					end
					n_taddr = q_item.dev_addr;
					n_treg = q_item.reg_addr;
					n_goal = CW'(q_item.count);
					n_byte = '0;
					n_bit = 3'd0;
					n_shift = 8'd0;
					n_stat = ST_OK;
					n_nack = 1'b0;
					n_phase = PH_START;
					n_slot = 2'd0;
					enter = 1'b1;
				end
			end
		end
		if (enter) begin
			n_pins = pins_for(n_phase, n_slot, n_shift, n_byte >= n_goal);
			n_delay = (qd_q == 8'd0) ? 8'd1 : qd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_q <= QD_RESET;
			phase_q <= PH_IDLE;
			slot_q <= 2'd0;
			delay_q <= 8'd0;
			bit_q <= 3'd0;
			shift_q <= 8'd0;
			byte_q <= '0;
			fill_q <= '0;
			taddr_q <= 7'd0;
			treg_q <= 8'd0;
			goal_q <= '0;
			rd_q <= 1'b0;
			stat_q <= ST_OK;
			nack_q <= 1'b0;
			pins_q <= PINS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				qd_q <= cfg_wdata;
			end
			phase_q <= n_phase;
			slot_q <= n_slot;
			delay_q <= n_delay;
			bit_q <= n_bit;
			shift_q <= n_shift;
			byte_q <= n_byte;
			fill_q <= n_fill;
			taddr_q <= n_taddr;
			treg_q <= n_treg;
			goal_q <= n_goal;
			rd_q <= n_rd;
			stat_q <= n_stat;
			nack_q <= n_nack;
			pins_q <= n_pins;
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			scl_out <= n_pins.scl;
			scl_oe <= n_pins.scl_oe;
			sda_out <= n_pins.sda;
			sda_oe <= n_pins.sda_oe;
			rd_data <= o_rdata;
			rd_valid <= o_rvalid;
			done_res <= o_done;
			status <= o_done ? n_stat : ST_OK;
			bytes_done <= o_done ? 5'(n_byte) : 5'd0;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[rtl/core/i2c_master_register_access_core.sv]
// I2C master for register writes and reads, driven by a stream of command beats.
// Input channel (in_valid/in_ready) carries func, dev_addr, reg_addr, data_byte,
// byte_count and sda_in. Func selects push of a write byte, start write, start
// read or a time tick. Every input beat yields exactly one output beat on the
// out_valid/out_ready channel with the pin levels, any received byte, and the
// done flag with status and byte count when a transaction finishes.
// Input beats enter a two-entry queue; the engine takes one beat per cycle while
// the output register is free or being read and places its result there. When
// the receiver stalls, the result is held, the queue fills and in_ready drops
// after at most two more beats. The write buffer is a RAM with a registered read
// port that is prefetched one byte ahead. The user must write quarter_delay through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this. Reset
// empties the queue, sets quarter_delay to 5 and returns the engine to idle; the
// pin outputs are not reset and no clearing pass runs.
`default_nettype none
module i2c_master_register_access_core import i2cm_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] func,
	input wire logic [6:0] dev_addr,
	input wire logic [7:0] reg_addr,
	input wire logic [7:0] data_byte,
	input wire logic [4:0] byte_count,
	input wire logic sda_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic scl_out,
	output logic scl_oe,
	output logic sda_out,
	output logic sda_oe,
	output logic [7:0] rd_data,
	output logic rd_valid,
	output logic done_res,
	output logic [2:0] status,
	output logic [4:0] bytes_done
);
	logic q_valid;
	logic q_pop;
	item_t q_item;

	i2cm_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.dev_addr(dev_addr),
		.reg_addr(reg_addr),
		.data_byte(data_byte),
		.byte_count(byte_count),
		.sda_in(sda_in),
		.q_pop(q_pop),
		.q_valid(q_valid),
		.q_item(q_item)
	);

	i2cm_back #(.MAX_BYTES(MAX_BYTES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.scl_oe(scl_oe),
		.sda_out(sda_out),
		.sda_oe(sda_oe),
		.rd_data(rd_data),
		.rd_valid(rd_valid),
		.done_res(done_res),
		.status(status),
		.bytes_done(bytes_done)
	);

`ifndef SYNTHESIS
	a_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!scl_oe || !sda_oe) |-> (scl_oe || scl_out) && (sda_oe || sda_out))
		else $error("released line not reported high");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && rd_valid))
		else $error("done and received byte in one beat");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK && bytes_done == 5'd0)
		else $error("status without done");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("taken beat produced no result");
`endif
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
	import i2cm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 60;

	typedef struct {
		logic scl;
		logic scl_oe;
		logic sda;
		logic sda_oe;
		logic [7:0] data;
		logic data_valid;
		logic done;
		logic [2:0] code;
		logic [4:0] nbytes;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FN_TICK;
	logic [6:0] dev_addr = '0;
	logic [7:0] reg_addr = '0;
	logic [7:0] data_byte = '0;
	logic [4:0] byte_count = '0;
	logic sda_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic scl_out, scl_oe, sda_out, sda_oe;
	logic [7:0] rd_data;
	logic rd_valid, done_res;
	logic [2:0] status;
	logic [4:0] bytes_done;

	i2c_master_register_access_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.dev_addr(dev_addr),
		.reg_addr(reg_addr),
		.data_byte(data_byte),
		.byte_count(byte_count),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.scl_oe(scl_oe),
		.sda_out(sda_out),
		.sda_oe(sda_oe),
		.rd_data(rd_data),
		.rd_valid(rd_valid),
		.done_res(done_res),
		.status(status),
		.bytes_done(bytes_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bus engine state.
	logic [7:0] qd;
	phase_t ph;
	int unsigned step_slot, dleft, bidx, byidx, fill, goal;
	logic [7:0] sreg;
	logic [6:0] taddr;
	logic [7:0] treg;
	logic isrd, nack;
	logic [2:0] stcode;
	logic [7:0] wbuf [MAX_BYTES_DEF];
	pins_t pins;
	logic o_valid, o_done;
	logic [7:0] o_data;

	beat_t bus_beats [$];
	int errors = 0;
	int items_sent = 0;
	int beats_checked = 0;
	int writes_run = 0;
	int reads_run = 0;
	int burst_left = 0;

	function automatic void drive_pins(logic cd, logic c, logic dd, logic d);
		pins.scl_oe = cd;
		pins.scl = cd ? c : 1'b1;
		pins.sda_oe = dd;
		pins.sda = dd ? d : 1'b1;
	endfunction

	function automatic void show_slot();
		logic hi;
		hi = (step_slot == 1);
		case (ph)
			PH_START, PH_RSTART: drive_pins(1'b1, step_slot < 2, 1'b1, step_slot == 0);
			PH_AW_TX, PH_REG_TX, PH_DAT_TX, PH_AR_TX: drive_pins(1'b1, hi, 1'b1, sreg[7]);
			PH_AW_ACK, PH_REG_ACK, PH_DAT_ACK, PH_AR_ACK, PH_RX_BIT:
				drive_pins(1'b1, step_slot < 2, 1'b0, 1'b1);
			PH_RX_PRE: drive_pins(1'b1, 1'b0, 1'b0, 1'b1);
			PH_RX_ANS: drive_pins(1'b1, hi, 1'b1, byidx >= goal);
			PH_STOP: drive_pins(1'b1, 1'b1, 1'b1, step_slot[0]);
			default: drive_pins(1'b0, 1'b1, 1'b0, 1'b1);
		endcase
		dleft = (qd == 0) ? 1 : qd;
	endfunction

	function automatic void goto_phase(phase_t p);
		ph = p;
		step_slot = 0;
	endfunction

	function automatic void load_byte(phase_t p, logic [7:0] b);
		sreg = b;
		bidx = 0;
		goto_phase(p);
	endfunction

	function automatic void stop_with(logic [2:0] c);
		stcode = c;
		goto_phase(PH_STOP);
	endfunction

	function automatic void finish_phase();
		case (ph)
			PH_START: load_byte(PH_AW_TX, {taddr, RW_BIT_WRITE});
			PH_AW_TX, PH_REG_TX, PH_DAT_TX, PH_AR_TX:
				if (bidx < 7) begin
					bidx++;
					sreg = sreg << 1;
					step_slot = 0;
				end else begin
					goto_phase(phase_t'(ph + 1));
				end
			PH_AW_ACK:
				if (nack) stop_with(isrd ? ST_RD_ADDR_NACK : ST_WR_ADDR_NACK);
				else load_byte(PH_REG_TX, treg);
			PH_REG_ACK:
				if (nack) stop_with(isrd ? ST_RD_REG_NACK : ST_WR_REG_NACK);
				else if (isrd) goto_phase(PH_RSTART);
				else if (goal == 0) stop_with(ST_OK);
				else load_byte(PH_DAT_TX, wbuf[0]);
			PH_DAT_ACK:
				if (nack) begin
					stop_with(byidx + 1 == goal ? ST_OK : ST_WR_REG_NACK);
				end else begin
					byidx++;
					if (byidx >= goal || byidx >= MAX_BYTES_DEF) stop_with(ST_OK);
					else load_byte(PH_DAT_TX, wbuf[byidx]);
				end
			PH_RSTART: load_byte(PH_AR_TX, {taddr, RW_BIT_READ});
			PH_AR_ACK:
				if (nack) stop_with(ST_RD_ADDRR_NACK);
				else goto_phase(PH_RX_PRE);
			PH_RX_PRE: begin
				bidx = 0;
				sreg = 0;
				goto_phase(PH_RX_BIT);
			end
			PH_RX_BIT:
				if (bidx < 7) begin
					bidx++;
					step_slot = 0;
				end else begin
					byidx++;
					goto_phase(PH_RX_ANS);
				end
			PH_RX_ANS:
				if (byidx >= goal) stop_with(ST_OK);
				else goto_phase(PH_RX_PRE);
			default: goto_phase(PH_IDLE);
		endcase
	endfunction

	function automatic void bus_tick(logic s);
		int unsigned last;
		if (ph == PH_IDLE) return;
		if (dleft > 1) begin
			dleft--;
			return;
		end
		dleft = 0;
		if (step_slot == 0) begin
			if (ph inside {PH_AW_ACK, PH_REG_ACK, PH_DAT_ACK, PH_AR_ACK}) nack = s;
			if (ph == PH_RX_BIT) begin
				sreg = {sreg[6:0], s};
				if (bidx == 7) begin
					o_valid = 1'b1;
					o_data = sreg;
				end
			end
		end
		if (ph == PH_STOP && step_slot >= 1) begin
			drive_pins(1'b0, 1'b1, 1'b0, 1'b1);
			o_done = 1'b1;
			goto_phase(PH_IDLE);
			return;
		end
		last = (ph == PH_RX_PRE) ? 0 : (ph == PH_STOP) ? 1 : 2;
		if (step_slot < last) step_slot++;
		else finish_phase();
		show_slot();
	endfunction

	function automatic beat_t predict_beat(kind_t f, logic [6:0] a, logic [7:0] r,
			logic [7:0] d, logic [4:0] c, logic s);
		beat_t b;
		int unsigned n;
		o_valid = 1'b0;
		o_data = 8'd0;
		o_done = 1'b0;
		if (f == FN_TICK) begin
			bus_tick(s);
		end else if (ph == PH_IDLE) begin
			if (f == FN_PUSH) begin
				if (fill < MAX_BYTES_DEF) begin
					wbuf[fill] = d;
					fill++;
				end
			end else begin
				n = (c > MAX_BYTES_DEF) ? MAX_BYTES_DEF : c;
				isrd = (f == FN_START_RD);
				if (isrd && n == 0) n = 1;
				if (!isrd) fill = 0;
				taddr = a;
				treg = r;
				goal = n;
				byidx = 0;
				bidx = 0;
				sreg = 0;
				stcode = ST_OK;
				nack = 1'b0;
				goto_phase(PH_START);
				show_slot();
			end
		end
		b.scl = pins.scl;
		b.scl_oe = pins.scl_oe;
		b.sda = pins.sda;
		b.sda_oe = pins.sda_oe;
		b.data = o_data;
		b.data_valid = o_valid;
		b.done = o_done;
		b.code = o_done ? stcode : 3'd0;
		b.nbytes = o_done ? byidx[4:0] : 5'd0;
		return b;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
	endtask

	always @(posedge clk) begin
		beat_t e;
		if (out_valid && out_ready) begin
			if (bus_beats.size() == 0) begin
				errors++;
				$display("unexpected result beat at %0t", $time);
			end else begin
				e = bus_beats.pop_front();
				beats_checked++;
				if (scl_out !== e.scl) report("scl_out", scl_out, e.scl);
				if (scl_oe !== e.scl_oe) report("scl_oe", scl_oe, e.scl_oe);
				if (sda_out !== e.sda) report("sda_out", sda_out, e.sda);
				if (sda_oe !== e.sda_oe) report("sda_oe", sda_oe, e.sda_oe);
				if (rd_data !== e.data) report("rd_data", rd_data, e.data);
				if (rd_valid !== e.data_valid) report("rd_valid", rd_valid, e.data_valid);
				if (done_res !== e.done) report("done_res", done_res, e.done);
				if (status !== e.code) report("status", status, e.code);
				if (bytes_done !== e.nbytes) report("bytes_done", bytes_done, e.nbytes);
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired at %0t", $time);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	logic [15:0] stall_mask = 16'hFFFF;
	int stall_pos = 0;
	always @(negedge clk) begin
		if (stall_pos == 63) begin
			case ($urandom_range(0, 3))
				0: stall_mask <= 16'hFFFF;
				1: stall_mask <= 16'($urandom) | 16'h8001;
				default: stall_mask <= 16'($urandom);
			endcase
		end
		stall_pos <= (stall_pos + 1) % 64;
		out_ready <= arst_n && (stall_mask[stall_pos % 16] || stall_mask == 16'd0);
	end

	task automatic send_item(kind_t f, logic [6:0] a, logic [7:0] r, logic [7:0] d,
			logic [4:0] c, logic s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		bus_beats.push_back(predict_beat(f, a, r, d, c, s));
		in_valid <= 1'b1;
		func <= f;
		dev_addr <= a;
		reg_addr <= r;
		data_byte <= d;
		byte_count <= c;
		sda_in <= s;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_rand(kind_t f);
		send_item(f, 7'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
	endtask

	task automatic set_delay(logic [7:0] v);
		in_valid <= 1'b0;
		burst_left = 0;
		while (bus_beats.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 8'($urandom);
		qd = v;
	endtask

	// Runs one transaction to its stop. A forced NACK lands on phase nack_ph (and on data
	// byte nack_byte for data acks); with noisy set, acks also fail at random and ignored
	// commands are mixed in.
	task automatic run_transfer(kind_t f, logic [6:0] a, logic [7:0] r, logic [4:0] c,
			phase_t nack_ph, int nack_byte, bit noisy);
		logic s;
		if (f == FN_START_RD) reads_run++;
		else writes_run++;
		send_item(f, a, r, 8'($urandom), c, 1'($urandom));
		while (ph != PH_IDLE) begin
			if (noisy && $urandom_range(0, 24) == 0) begin
				send_rand(kind_t'($urandom_range(0, 2)));
			end else begin
				if (ph inside {PH_AW_ACK, PH_REG_ACK, PH_DAT_ACK, PH_AR_ACK}) begin
					s = (ph == nack_ph && (ph != PH_DAT_ACK || byidx == nack_byte))
						|| (noisy && $urandom_range(0, 11) == 0);
				end else begin
					s = 1'($urandom);
				end
				send_item(FN_TICK, 7'($urandom), 8'($urandom), 8'($urandom),
					5'($urandom), s);
			end
		end
	endtask

	task automatic test_buffer_fill();
		send_item(FN_PUSH, 7'h7F, 8'hFF, 8'h00, 5'h1F, 1'b1);
		send_item(FN_PUSH, 7'h00, 8'h00, 8'hFF, 5'h00, 1'b0);
		repeat (15) send_rand(FN_PUSH);
		send_item(FN_TICK, 7'h00, 8'h00, 8'h00, 5'h00, 1'b0);
	endtask

	task automatic test_write_paths();
		set_delay(8'd0);
		run_transfer(FN_START_WR, 7'h7F, 8'hFF, 5'd0, PH_IDLE, 0, 1'b0);
		run_transfer(FN_START_WR, 7'h55, 8'hA5, 5'd1, PH_DAT_ACK, 0, 1'b0);
		run_transfer(FN_START_WR, 7'h2A, 8'h5A, 5'd3, PH_DAT_ACK, 0, 1'b0);
		run_transfer(FN_START_WR, 7'h11, 8'h22, 5'd2, PH_REG_ACK, 0, 1'b0);
		run_transfer(FN_START_WR, 7'h33, 8'h44, 5'd31, PH_IDLE, 0, 1'b0);
	endtask

	task automatic test_read_paths();
		set_delay(8'd1);
		run_transfer(FN_START_RD, 7'h7F, 8'h00, 5'd0, PH_IDLE, 0, 1'b0);
		run_transfer(FN_START_RD, 7'h12, 8'h34, 5'd2, PH_AW_ACK, 0, 1'b0);
		run_transfer(FN_START_RD, 7'h12, 8'h34, 5'd2, PH_REG_ACK, 0, 1'b0);
		run_transfer(FN_START_RD, 7'h12, 8'h34, 5'd2, PH_AR_ACK, 0, 1'b0);
	endtask

	task automatic test_slow_timing();
		set_delay(8'd2);
		run_transfer(FN_START_WR, 7'h40, 8'h01, 5'd1, PH_AW_ACK, 0, 1'b0);
		set_delay(8'd1);
	endtask

	task automatic test_random_traffic();
		int goal_items;
		int n;
		goal_items = items_sent + RANDOM_ITEMS;
		while (items_sent < goal_items) begin
			if ($urandom_range(0, 9) == 0)
				set_delay($urandom_range(0, 9) == 0 ? 8'($urandom_range(4, 7))
					: 8'($urandom_range(0, 3)));
			n = $urandom_range(0, 4);
			repeat (n) send_rand($urandom_range(0, 3) == 0 ? FN_TICK : FN_PUSH);
			n = $urandom_range(0, 7) == 0 ? $urandom_range(17, 31) : $urandom_range(0, 4);
			run_transfer($urandom_range(0, 1) ? FN_START_RD : FN_START_WR, 7'($urandom),
				8'($urandom), 5'(n), PH_IDLE, 0, 1'b1);
		end
	endtask

	initial begin
		qd = QD_RESET;
		ph = PH_IDLE;
		step_slot = 0;
		dleft = 0;
		bidx = 0;
		byidx = 0;
		fill = 0;
		goal = 0;
		sreg = 0;
		taddr = 0;
		treg = 0;
		isrd = 0;
		nack = 0;
		stcode = ST_OK;
		drive_pins(1'b0, 1'b1, 1'b0, 1'b1);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_buffer_fill();
		test_write_paths();
		test_read_paths();
		test_slow_timing();
		test_random_traffic();
		in_valid <= 1'b0;
		while (bus_beats.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		$display("Ran %0d write and %0d read transfers over %0d command beats.",
			writes_run, reads_run, items_sent);
		$display("Checked %0d result beats, %0d mismatches.", beats_checked, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

[i2c_master_register_access_core.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_ram.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_register_access_core.sv
tb/tb_top.sv
